>>> rtl/ttm_pkg.sv
package ttm_pkg;

    // fixed widths of the stream fields
    localparam int TIME_BITS      = 32;
    localparam int COUNT_BITS_DEF = 16;
    localparam int BEATS_W        = 16;
    localparam int TENTHS_W       = 27;
    localparam int BPM_W          = 16;
    localparam int MPM2_W         = 15;
    localparam int MPM3_W         = 15;
    localparam int MPM4_W         = 14;
    localparam int METER_W        = 2;
    localparam int S_TDATA_W      = 32;
    localparam int M_TDATA_W      = 120;
    localparam int M_TUSER_W      = 2;

    localparam logic [BPM_W-1:0]   BPM_MAX     = 16'hFFFF;
    localparam logic [15:0]        BPM_SCALE   = 16'd60000;
    localparam logic [6:0]         TENTHS_DIV  = 7'd100;
    localparam logic [15:0]        THIRD_RECIP = 16'hAAAB;
    localparam logic [BEATS_W-1:0] BEATS_MAX   = 16'hFFFF;

    // tenths: (padded + 50) / 4, then divide by 25 with a reciprocal, exact for 32 bits
    localparam logic [5:0]         TENTHS_HALF  = 6'd50;
    localparam logic [31:0]        TENTHS_RECIP = 32'h51EB_851F;
    localparam int                 TENTHS_SHIFT = 35;

    localparam logic CMD_TAP   = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    typedef enum logic [1:0] {
        METER_BPM,
        METER_TWO,
        METER_THREE,
        METER_FOUR
    } meter_t;

    typedef logic [3:0] step_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_BUMP,
        OP_SPAN,
        OP_DIV_EXTRA,
        OP_PAD,
        OP_DIV_BPM,
        OP_SET_BPM,
        OP_TENTHS_PREP,
        OP_TENTHS_MUL,
        OP_SET_TENTHS,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_NO_INPUT,
        C_CMD,
        C_FIRST,
        C_SPAN_ZERO,
        C_DIV_BUSY,
        C_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    typedef struct packed {
        logic no_input;
        logic cmd;
        logic first;
        logic span_zero;
        logic div_busy;
        logic out_blocked;
    } seq_status_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_ROUND
    } div_state_t;

    localparam step_t STEP_FETCH      = 4'd0;
    localparam step_t STEP_BUMP       = 4'd1;
    localparam step_t STEP_SPAN       = 4'd2;
    localparam step_t STEP_EXTRA      = 4'd3;
    localparam step_t STEP_EXTRA_W    = 4'd4;
    localparam step_t STEP_PAD        = 4'd5;
    localparam step_t STEP_BPM        = 4'd6;
    localparam step_t STEP_BPM_W      = 4'd7;
    localparam step_t STEP_SET_BPM    = 4'd8;
    localparam step_t STEP_TENTHS     = 4'd9;
    localparam step_t STEP_TENTHS_MUL = 4'd10;
    localparam step_t STEP_SET_TEN    = 4'd11;
    localparam step_t STEP_EMIT       = 4'd12;
    localparam step_t STEP_RETURN     = 4'd13;

    // microprogram: jump to target when cond holds, else fall through
    function automatic ctrl_word_t ttm_rom(step_t step);
        ctrl_word_t cw;
        begin
            case (step)
                STEP_FETCH:      cw = '{OP_FETCH,       C_NO_INPUT,    STEP_FETCH};
                STEP_BUMP:       cw = '{OP_BUMP,        C_CMD,         STEP_EMIT};
                STEP_SPAN:       cw = '{OP_SPAN,        C_FIRST,       STEP_TENTHS};
                STEP_EXTRA:      cw = '{OP_DIV_EXTRA,   C_NEXT,        STEP_FETCH};
                STEP_EXTRA_W:    cw = '{OP_NOP,         C_DIV_BUSY,    STEP_EXTRA_W};
                STEP_PAD:        cw = '{OP_PAD,         C_SPAN_ZERO,   STEP_TENTHS};
                STEP_BPM:        cw = '{OP_DIV_BPM,     C_NEXT,        STEP_FETCH};
                STEP_BPM_W:      cw = '{OP_NOP,         C_DIV_BUSY,    STEP_BPM_W};
                STEP_SET_BPM:    cw = '{OP_SET_BPM,     C_NEXT,        STEP_FETCH};
                STEP_TENTHS:     cw = '{OP_TENTHS_PREP, C_NEXT,        STEP_FETCH};
                STEP_TENTHS_MUL: cw = '{OP_TENTHS_MUL,  C_NEXT,        STEP_FETCH};
                STEP_SET_TEN:    cw = '{OP_SET_TENTHS,  C_NEXT,        STEP_FETCH};
                STEP_EMIT:       cw = '{OP_EMIT,        C_OUT_BLOCKED, STEP_EMIT};
                default:         cw = '{OP_NOP,         C_ALWAYS,      STEP_FETCH};
            endcase
            return cw;
        end
    endfunction

endpackage

>>> rtl/ttm_div.sv
module ttm_div
    import ttm_pkg::*;
#(
    parameter int NUM_W = 33,
    parameter int DEN_W = 33
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic [NUM_W:0]   quot
);

    localparam int CNT_W = $clog2(NUM_W);

    div_state_t       state_reg, state_next;
    logic [NUM_W-1:0] num_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W:0]   quot_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             ge;
    logic             round_up;

    // one restoring step per cycle
    assign shifted  = {rem_reg, num_reg[NUM_W-1]};
    assign ge       = shifted >= {1'b0, den_reg};
    assign diff     = shifted - {1'b0, den_reg};
    // half-up: remainder at least half the divisor
    assign round_up = {rem_reg, 1'b0} >= {1'b0, den_reg};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            DIV_IDLE:  if (start) state_next = DIV_RUN;
            DIV_RUN:   if (cnt_reg == '0) state_next = DIV_ROUND;
            DIV_ROUND: state_next = DIV_IDLE;
            default:   state_next = DIV_IDLE;
        endcase
    end

    always_comb begin
        case (state_reg)
            DIV_IDLE: busy = 1'b0;
            default:  busy = 1'b1;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            DIV_IDLE: begin
                if (start) begin
                    num_reg <= num;
                    den_reg <= den;
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(NUM_W - 1);
                end
            end
            DIV_RUN: begin
                rem_reg <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
            end
            DIV_ROUND: begin
                quot_reg <= {1'b0, num_reg} + (NUM_W+1)'(round_up);
            end
            default: begin
            end
        endcase
    end

    assign quot = quot_reg;

endmodule

>>> rtl/ttm_seq.sv
module ttm_seq
    import ttm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  seq_status_t status,
    output ctrl_word_t  ctrl
);

    step_t pc_reg, pc_next;
    logic  take;

    assign ctrl = ttm_rom(pc_reg);

    always_comb begin
        case (ctrl.cond)
            C_NEXT:        take = 1'b0;
            C_ALWAYS:      take = 1'b1;
            C_NO_INPUT:    take = status.no_input;
            C_CMD:         take = status.cmd;
            C_FIRST:       take = status.first;
            C_SPAN_ZERO:   take = status.span_zero;
            C_DIV_BUSY:    take = status.div_busy;
            C_OUT_BLOCKED: take = status.out_blocked;
            default:       take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_FETCH;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> rtl/tap_tempo_meter.sv
// flow: a tap beat runs fetch, bump and span, then the bit-serial divider for the average
//   interval, pad, the divider again for the tempo (skipped for a zero span), tenths from a
//   reciprocal multiply, and emit; a first tap skips to tenths, a reset beat goes to emit
// throughput: one beat in flight, the next beat is taken at the fetch step after the result
//   is loaded; a stalled master side holds only the emit step
// reset: aresetn is synchronous, active low; clears tempo state, meter select and handshakes
module tap_tempo_meter
    import ttm_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // input beats
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] tap_time_ms
    input  logic                 s_tuser,   // [0] cmd

    // result beats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] beats, [42:16] elapsed_tenths, [58:43] bpm, [73:59] mpm_two,
    // [88:74] mpm_three, [102:89] mpm_four, [118:103] chosen_value, [119] zero
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] rate_valid, [1] saturated

    // meter select register
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [METER_W-1:0]   cfg_data
);

    // divider widths: numerator holds count*60000 or the span, denominator the padded span
    localparam int PROD_W = COUNT_BITS + 16;
    localparam int DEN_W  = TIME_BITS + 1;
    localparam int NUM_W  = (PROD_W > DEN_W) ? PROD_W : DEN_W;

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    ctrl_word_t  ctrl;
    seq_status_t status;

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    logic                   cmd_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [TIME_BITS-1:0]   start_reg;
    logic                   started_reg;
    logic [BPM_W-1:0]       held_reg;
    logic [TIME_BITS-1:0]   span_reg;
    logic [DEN_W-1:0]       padded_reg;
    logic [TENTHS_W-1:0]    tenths_reg;
    logic [TIME_BITS-1:0]   tenths_y_reg;
    logic [2*TIME_BITS-1:0] tenths_prod_reg;
    logic                   valid_reg;
    logic                   sat_reg;
    meter_t                 meter_reg;

    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg;
    logic [M_TUSER_W-1:0]  m_tuser_reg;

    // divider hookup
    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic                  div_busy;
    logic [NUM_W:0]        div_q;

    // result shaping
    logic [PROD_W-1:0]     scaled;
    logic [DEN_W:0]        padded_half;
    logic [31:0]           count_w;
    logic [BEATS_W-1:0]    beats;
    logic [MPM2_W-1:0]     mpm_two;
    logic [MPM3_W-1:0]     mpm_three;
    logic [MPM4_W-1:0]     mpm_four;
    logic [31:0]           third_prod;
    logic [BPM_W-1:0]      chosen;
    logic                  emit;

    // ---------------------------------------------------------------
    // status flags for conditional jumps
    // ---------------------------------------------------------------
    assign status.no_input    = !s_tvalid;
    assign status.cmd         = (cmd_reg == CMD_RESET);
    assign status.first       = (count_reg < COUNT_BITS'(2));
    assign status.span_zero   = (span_reg == '0);
    assign status.div_busy    = div_busy;
    assign status.out_blocked = m_tvalid_reg && !m_tready;

    ttm_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // input is only taken on the fetch step
    assign s_tready  = (ctrl.op == OP_FETCH);
    assign cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // divider operand select; product gets registered in the divider
    // ---------------------------------------------------------------
    assign scaled = PROD_W'(count_reg) * PROD_W'(BPM_SCALE);

    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (ctrl.op)
            OP_DIV_EXTRA: begin
                // average interval over count-1 gaps
                div_start = 1'b1;
                div_num   = NUM_W'(span_reg);
                div_den   = DEN_W'(count_reg - 1'b1);
            end
            OP_DIV_BPM: begin
                div_start = 1'b1;
                div_num   = NUM_W'(scaled);
                div_den   = padded_reg;
            end
            default: begin
            end
        endcase
    end

    ttm_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_q)
    );

    // half-up rounding for tenths: add half of 100 before the floor division
    assign padded_half = {1'b0, padded_reg} + (DEN_W+1)'(TENTHS_HALF);

    // ---------------------------------------------------------------
    // tempo state: held across beats, cleared by reset or a reset beat
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            start_reg   <= '0;
            started_reg <= 1'b0;
            held_reg    <= '0;
            meter_reg   <= METER_BPM;
        end else begin
            if (cfg_valid && cfg_ready) begin
                meter_reg <= meter_t'(cfg_data);
            end
            case (ctrl.op)
                OP_BUMP: begin
                    if (cmd_reg == CMD_RESET) begin
                        count_reg   <= '0;
                        start_reg   <= '0;
                        started_reg <= 1'b0;
                        held_reg    <= '0;
                    end else begin
                        // saturating beat count
                        if (count_reg != '1) begin
                            count_reg <= count_reg + 1'b1;
                        end
                        // first tap fixes the start time
                        if (!started_reg) begin
                            start_reg   <= now_reg;
                            started_reg <= 1'b1;
                        end
                    end
                end
                OP_PAD: begin
                    // zero span means an unbounded tempo
                    if (span_reg == '0) begin
                        held_reg <= BPM_MAX;
                    end
                end
                OP_SET_BPM: begin
                    if (div_q > (NUM_W+1)'(BPM_MAX)) begin
                        held_reg <= BPM_MAX;
                    end else begin
                        held_reg <= div_q[BPM_W-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // per-beat working registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cmd_reg <= s_tuser;
            now_reg <= s_tdata[TIME_BITS-1:0];
        end
        case (ctrl.op)
            OP_BUMP: begin
                valid_reg  <= 1'b0;
                sat_reg    <= 1'b0;
                tenths_reg <= '0;
            end
            OP_SPAN: begin
                // wraps modulo 2^TIME_BITS
                span_reg   <= now_reg - start_reg;
                padded_reg <= {1'b0, now_reg - start_reg};
            end
            OP_PAD: begin
                // average interval stands in for the first beat
                valid_reg  <= 1'b1;
                padded_reg <= DEN_W'(span_reg) + div_q[DEN_W-1:0];
                if (span_reg == '0) begin
                    sat_reg <= 1'b1;
                end
            end
            OP_SET_BPM: begin
                if (div_q > (NUM_W+1)'(BPM_MAX)) begin
                    sat_reg <= 1'b1;
                end
            end
            OP_TENTHS_PREP: begin
                // divide by 4 here, the multiply handles the remaining 25
                tenths_y_reg <= padded_half[DEN_W:2];
            end
            OP_TENTHS_MUL: begin
                tenths_prod_reg <= (2*TIME_BITS)'(tenths_y_reg) * (2*TIME_BITS)'(TENTHS_RECIP);
            end
            OP_SET_TENTHS: begin
                // padded span is at most twice the 32-bit span, fits 27 bits
                tenths_reg <= tenths_prod_reg[TENTHS_SHIFT +: TENTHS_W];
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // result fields
    // ---------------------------------------------------------------
    assign count_w    = 32'(count_reg);
    assign beats      = (count_w > 32'(BEATS_MAX)) ? BEATS_MAX : count_w[BEATS_W-1:0];
    assign mpm_two    = held_reg[BPM_W-1:1];
    assign mpm_four   = held_reg[BPM_W-1:2];
    // divide by three: multiply by reciprocal, exact for 16-bit values
    assign third_prod = 32'(held_reg) * 32'(THIRD_RECIP);
    assign mpm_three  = third_prod[17 +: MPM3_W];

    always_comb begin
        case (meter_reg)
            METER_BPM:   chosen = held_reg;
            METER_TWO:   chosen = BPM_W'(mpm_two);
            METER_THREE: chosen = BPM_W'(mpm_three);
            METER_FOUR:  chosen = BPM_W'(mpm_four);
            default:     chosen = held_reg;
        endcase
    end

    // ---------------------------------------------------------------
    // output register; emit step waits until it is free
    // ---------------------------------------------------------------
    assign emit = (ctrl.op == OP_EMIT) && !status.out_blocked;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {1'b0, chosen, mpm_four, mpm_three, mpm_two,
                            held_reg, tenths_reg, beats};
            m_tuser_reg <= {sat_reg, valid_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

>>> sim/tempo_checker.sv
`timescale 1ns / 1ps

module tempo_checker
    import ttm_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] tap_time_ms
    input  logic                 s_tuser,   // [0] cmd
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // [15:0] beats, [42:16] elapsed_tenths, [58:43] bpm, [73:59] mpm_two,
    // [88:74] mpm_three, [102:89] mpm_four, [118:103] chosen_value
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [M_TUSER_W-1:0] m_tuser,   // [0] rate_valid, [1] saturated
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [METER_W-1:0]   cfg_data,
    output int                   n_waiting,
    output int                   n_errors
);

    typedef struct packed {
        logic [BEATS_W-1:0]  beats;
        logic [TENTHS_W-1:0] tenths;
        logic [BPM_W-1:0]    bpm;
        logic [MPM2_W-1:0]   two;
        logic [MPM3_W-1:0]   three;
        logic [MPM4_W-1:0]   four;
        logic [BPM_W-1:0]    chosen;
        logic                rate_valid;
        logic                saturated;
    } tempo_t;

    localparam logic [63:0] TENTHS_TOP = (64'd1 << TENTHS_W) - 64'd1;

    // tempo state as the block should hold it
    logic [BEATS_W-1:0]   tap_count;
    logic [TIME_BITS-1:0] first_tap_ms;
    logic                 counting;
    logic [BPM_W-1:0]     tempo_bpm;
    meter_t               meter_sel;
    tempo_t               pending_tempos[$];

    // quotient rounded half up, divisor nonzero
    function automatic logic [63:0] div_half_up(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = num / den;
        rem = num % den;
        if (rem >= den - rem)
            quo = quo + 64'd1;
        return quo;
    endfunction

    function automatic tempo_t predict_tempo(input logic cmd, input logic [TIME_BITS-1:0] now_ms);
        tempo_t               res;
        logic [TIME_BITS-1:0] span;
        logic [63:0]          padded;
        logic [63:0]          extra;
        logic [63:0]          rate;
        logic [63:0]          tenths;
        res = '0;
        if (cmd == CMD_RESET) begin
            tap_count    = '0;
            first_tap_ms = '0;
            counting     = 1'b0;
            tempo_bpm    = '0;
            return res;
        end
        if (tap_count != BEATS_MAX)
            tap_count = tap_count + 1'b1;
        if (!counting) begin
            first_tap_ms = now_ms;
            counting     = 1'b1;
        end
        span   = now_ms - first_tap_ms;
        padded = 64'(span);
        if (tap_count > 1) begin
            // pad by the mean interval to cover the first beat
            extra          = div_half_up(64'(span), 64'(tap_count) - 64'd1);
            res.rate_valid = 1'b1;
            padded         = 64'(span) + extra;
            if (padded == 64'd0) begin
                tempo_bpm     = BPM_MAX;
                res.saturated = 1'b1;
            end else begin
                rate = div_half_up(64'(tap_count) * 64'(BPM_SCALE), padded);
                if (rate > 64'(BPM_MAX)) begin
                    tempo_bpm     = BPM_MAX;
                    res.saturated = 1'b1;
                end else begin
                    tempo_bpm = rate[BPM_W-1:0];
                end
            end
        end
        tenths = div_half_up(padded, 64'(TENTHS_DIV));
        if (tenths > TENTHS_TOP)
            tenths = TENTHS_TOP;
        res.beats  = tap_count;
        res.tenths = tenths[TENTHS_W-1:0];
        res.bpm    = tempo_bpm;
        res.two    = MPM2_W'(tempo_bpm / 2);
        res.three  = MPM3_W'(tempo_bpm / 3);
        res.four   = MPM4_W'(tempo_bpm / 4);
        case (meter_sel)
            METER_BPM:   res.chosen = tempo_bpm;
            METER_TWO:   res.chosen = BPM_W'(res.two);
            METER_THREE: res.chosen = BPM_W'(res.three);
            default:     res.chosen = BPM_W'(res.four);
        endcase
        return res;
    endfunction

    task automatic compare_field(input string what, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= 10)
                $display("tempo mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        tempo_t want;
        if (!aresetn) begin
            tap_count    = '0;
            first_tap_ms = '0;
            counting     = 1'b0;
            tempo_bpm    = '0;
            meter_sel    = METER_BPM;
            pending_tempos.delete();
            n_waiting    = 0;
            n_errors     = 0;
        end else begin
            if (cfg_valid && cfg_ready)
                meter_sel = meter_t'(cfg_data);
            if (m_tvalid && m_tready) begin
                if (pending_tempos.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("result beat with nothing expected: tdata %h", m_tdata);
                end else begin
                    want = pending_tempos.pop_front();
                    compare_field("beats", want.beats, m_tdata[15:0]);
                    compare_field("elapsed_tenths", want.tenths, m_tdata[42:16]);
                    compare_field("bpm", want.bpm, m_tdata[58:43]);
                    compare_field("mpm_two", want.two, m_tdata[73:59]);
                    compare_field("mpm_three", want.three, m_tdata[88:74]);
                    compare_field("mpm_four", want.four, m_tdata[102:89]);
                    compare_field("chosen_value", want.chosen, m_tdata[118:103]);
                    compare_field("rate_valid", want.rate_valid, m_tuser[0]);
                    compare_field("saturated", want.saturated, m_tuser[1]);
                end
            end
            if (s_tvalid && s_tready)
                pending_tempos.push_back(predict_tempo(s_tuser, s_tdata));
            n_waiting = pending_tempos.size();
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import ttm_pkg::*;

    // longest run of cycles with no beat moving anywhere before giving up
    localparam int STALL_LIMIT  = 4000;
    // receiver hold-off long enough to back the block up into its input
    localparam int HOLD_CYCLES  = 400;
    localparam int BEATS_PER_PHASE = 110;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [31:0] tap_time_ms
    logic                 s_tuser   = 1'b0; // [0] cmd
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;          // beats .. chosen_value, see block ports
    logic [M_TUSER_W-1:0] m_tuser;          // [0] rate_valid, [1] saturated
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [METER_W-1:0]   cfg_data  = '0;

    int n_waiting;
    int n_errors;

    // idle odds out of a hundred, per side
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;

    // long receiver hold-off, asked by the stimulus and counted by the receiver
    bit hold_req  = 1'b0;
    int hold_left = 0;

    int idle_cycles = 0;

    // running millisecond clock for well-formed tap sequences
    logic [31:0] clock_ms = 32'd0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    tap_tempo_meter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tempo_checker u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .n_waiting (n_waiting),
        .n_errors  (n_errors)
    );

    // receiver side: random stalls, or a counted hold-off when asked
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left  = hold_left - 1;
        end else if (hold_req) begin
            hold_req   = 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // watchdog: any beat on any channel restarts the count
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles = idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // called at a falling edge; leaves tvalid high so back-to-back beats never
    // see a low and a high scheduled in the same step
    task automatic send_beat(input logic cmd, input logic [31:0] tap_ms);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tap_ms;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // mostly steady taps with random spacing, some noise and reset beats
    task automatic send_random_beat;
        int pick;
        pick = $urandom_range(99);
        if (pick < 5) begin
            send_beat(CMD_RESET, $urandom);
        end else begin
            if (pick < 10)
                clock_ms = $urandom;
            else if (pick < 18)
                clock_ms = clock_ms + $urandom_range(3);
            else if (pick < 24)
                clock_ms = clock_ms + $urandom;
            else
                clock_ms = clock_ms + $urandom_range(3000, 100);
            send_beat(CMD_TAP, clock_ms);
        end
    endtask

    // sender stops until every result is back
    task automatic drain_results;
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (n_waiting != 0);
    endtask

    // block is idle here: nothing in flight
    task automatic write_meter(input meter_t sel);
        cfg_valid <= 1'b1;
        cfg_data  <= sel;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        meter_t phase_meter[4];
        phase_meter = '{METER_FOUR, METER_TWO, METER_THREE, METER_BPM};

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // first tap after reset, and timestamp zero is an ordinary time
        send_beat(CMD_TAP, 32'h0000_0000);
        // same time again: zero padded span saturates the tempo
        send_beat(CMD_TAP, 32'h0000_0000);
        send_beat(CMD_TAP, 32'd500);
        send_beat(CMD_TAP, 32'd1000);
        // reset beat, its timestamp is ignored
        send_beat(CMD_RESET, 32'hFFFF_FFFF);
        // span wraps through zero
        send_beat(CMD_TAP, 32'hFFFF_FF00);
        send_beat(CMD_TAP, 32'h0000_0100);
        send_beat(CMD_TAP, 32'h0000_0300);
        send_beat(CMD_RESET, 32'h0000_0000);
        // taps one ms apart, then a repeat: the third one pushes the tempo above range
        send_beat(CMD_TAP, 32'd1000);
        send_beat(CMD_TAP, 32'd1001);
        send_beat(CMD_TAP, 32'd1001);
        send_beat(CMD_RESET, 32'h5555_AAAA);
        // widest span: tenths near the top, tempo rounds to zero
        send_beat(CMD_TAP, 32'h0000_0000);
        send_beat(CMD_TAP, 32'hFFFF_FFFF);
        send_beat(CMD_TAP, 32'h8000_0000);
        send_beat(CMD_RESET, 32'hAAAA_5555);
        // steady half-second taps, 120 bpm
        send_beat(CMD_TAP, 32'h1234_5678);
        send_beat(CMD_TAP, 32'h1234_586C);
        send_beat(CMD_TAP, 32'h1234_5A60);
        send_beat(CMD_TAP, 32'h1234_5C54);

        // random phases, each with its own meter select and idle pattern
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            write_meter(phase_meter[ph]);
            case (ph)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 65; end
                default: begin tx_idle_pct = 19; rx_stall_pct = 19; end
            endcase
            for (int n = 0; n < BEATS_PER_PHASE; n++) begin
                // receiver holds off while the sender keeps offering beats
                if (ph == 0 && n == 10)
                    hold_req = 1'b1;
                send_random_beat();
            end
        end

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        drain_results();
        repeat (150) @(negedge aclk);

        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
